>>> src/bbst_pkg.sv
// Shared constants and command codes for the bracket balance segment tree.
package bbst_pkg;

	// Default leaf count of the tree
	localparam int LEAVES_DEF = 1024;

	// Fixed field widths of the input and result transfers
	localparam int CMD_W = 2;
	localparam int POS_W = 10;
	localparam int LV_W  = 2;
	localparam int OUT_W = 12;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FLIP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

endpackage

>>> src/bbst_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module bbst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, read every cycle into the output register
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/bracket_balance_segment_tree.sv
// Top level: segment tree over a bracket sequence with update and balance query.
//
//  channel  direction  fields                                 handshake
//  in       input      cmd, position, leaf_value              in_valid / in_stall
//  out      output     balanced, total_sum, least_prefix      out_valid / out_stall
//
// A query's result appears in the output register in the cycle after its
// transfer. A write or flip walks up the tree with one node read and one node
// write per tree level on the node RAM. After reset all 2*W node RAM words,
// where W is LEAVES rounded up to a power of two, are swept to zero (2048
// words at 1024 leaves) with in_stall high. A query also waits while a stalled
// result is held; writes and flips are still taken then. Command 3, and writes
// or flips at positions at or beyond LEAVES, are taken and dropped.
module bracket_balance_segment_tree #(
	parameter int LEAVES = bbst_pkg::LEAVES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bbst_pkg::CMD_W-1:0]          cmd,
	input  logic [bbst_pkg::POS_W-1:0]          position,
	input  logic signed [bbst_pkg::LV_W-1:0]    leaf_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                balanced,
	output logic signed [bbst_pkg::OUT_W-1:0]   total_sum,
	output logic signed [bbst_pkg::OUT_W-1:0]   least_prefix
);

	import bbst_pkg::*;

	localparam int LOG_W = $clog2(LEAVES);
	localparam int IW    = LOG_W + 1;
	localparam int DEPTH = 2 << LOG_W;
	localparam int VW    = LOG_W + 2;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_LEAF  = 2'd2;
	localparam logic [1:0] ST_LEVEL = 2'd3;

	logic [1:0]           state_q;
	logic [IW-1:0]        clr_addr_q;
	logic [IW-1:0]        node_q;
	logic                 is_flip_q;
	logic signed [VW-1:0] wval_q;
	logic signed [VW-1:0] cur_sum_q;
	logic signed [VW-1:0] cur_min_q;
	logic signed [VW-1:0] root_sum_q;
	logic signed [VW-1:0] root_min_q;
	logic                 out_valid_q;
	logic                 balanced_q;
	logic [OUT_W-1:0]     total_q;
	logic [OUT_W-1:0]     least_q;

	logic                 in_xfer;
	logic                 pos_ok;
	logic                 do_update;
	logic                 do_query;
	logic [IW-1:0]        leaf_node;
	logic signed [VW-1:0] lv_ext;
	logic [IW-1:0]        parent;

	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	logic [2*VW-1:0]      wr_data;
	logic [IW-1:0]        rd_addr;
	logic [2*VW-1:0]      rd_data;

	logic signed [VW-1:0] rd_sum;
	logic signed [VW-1:0] rd_min;
	logic signed [VW-1:0] new_leaf;
	logic signed [VW-1:0] l_sum;
	logic signed [VW-1:0] l_min;
	logic signed [VW-1:0] r_min;
	logic signed [VW-1:0] via_right;
	logic signed [VW-1:0] par_sum;
	logic signed [VW-1:0] par_min;

	// Decode the input transfer
	assign in_stall  = (state_q != ST_IDLE) ||
	                   (out_valid_q && out_stall && (cmd == CMD_QUERY));
	assign in_xfer   = in_valid && !in_stall;
	assign pos_ok    = 32'(position) < 32'(LEAVES);
	assign do_update = in_xfer && pos_ok && ((cmd == CMD_WRITE) || (cmd == CMD_FLIP));
	assign do_query  = in_xfer && (cmd == CMD_QUERY);
	assign leaf_node = {1'b1, LOG_W'(position)};

	// Saturate the write value: the unused pattern counts as close
	assign lv_ext = (leaf_value == 2'sd1) ? VW'(1) :
	                (leaf_value == 2'sd0) ? '0 : '1;

	// Split the read word and form the new leaf
	assign rd_sum   = rd_data[2*VW-1:VW];
	assign rd_min   = rd_data[VW-1:0];
	assign new_leaf = is_flip_q ? -rd_sum : wval_q;

	// Combine the current child with its sibling
	assign parent    = {1'b0, node_q[IW-1:1]};
	assign l_sum     = node_q[0] ? rd_sum : cur_sum_q;
	assign l_min     = node_q[0] ? rd_min : cur_min_q;
	assign r_min     = node_q[0] ? cur_min_q : rd_min;
	assign via_right = l_sum + r_min;
	assign par_sum   = cur_sum_q + rd_sum;
	assign par_min   = (l_min < via_right) ? l_min : via_right;

	// Drive the RAM ports from the current step
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_addr_q;
		wr_data = '0;
		rd_addr = leaf_node;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_LEAF: begin
				wr_en   = 1'b1;
				wr_addr = node_q;
				wr_data = {new_leaf, new_leaf};
				rd_addr = node_q ^ IW'(1);
			end
			ST_LEVEL: begin
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = {par_sum, par_min};
				rd_addr = parent ^ IW'(1);
			end
			default: begin
			end
		endcase
	end

	bbst_ram #(
		.WIDTH (2*VW),
		.DEPTH (DEPTH)
	) u_nodes (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequence the clearing sweep and the walk up the tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			root_sum_q <= '0;
			root_min_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + IW'(1);
					if (clr_addr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (do_update) begin
						state_q <= ST_LEAF;
					end
				end
				ST_LEAF: begin
					state_q <= ST_LEVEL;
				end
				ST_LEVEL: begin
					if (parent == IW'(1)) begin
						root_sum_q <= par_sum;
						root_min_q <= par_min;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the command and the running node value
	always_ff @(posedge clk) begin
		if (do_update) begin
			node_q    <= leaf_node;
			is_flip_q <= (cmd == CMD_FLIP);
			wval_q    <= lv_ext;
		end else if (state_q == ST_LEAF) begin
			cur_sum_q <= new_leaf;
			cur_min_q <= new_leaf;
		end else if (state_q == ST_LEVEL) begin
			cur_sum_q <= par_sum;
			cur_min_q <= par_min;
			node_q    <= parent;
		end
	end

	// Load the result on a query transfer, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_query) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_query) begin
			balanced_q <= (root_sum_q == '0) && (root_min_q == '0);
			total_q    <= OUT_W'(32'(root_sum_q));
			least_q    <= OUT_W'(32'(root_min_q));
		end
	end

	assign out_valid    = out_valid_q;
	assign balanced     = balanced_q;
	assign total_sum    = total_q;
	assign least_prefix = least_q;

endmodule

>>> src/bbst_check.sv
// Port-level checker for the bracket balance segment tree, bound to the top level.
module bbst_check #(
	parameter int LEAVES = bbst_pkg::LEAVES_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [bbst_pkg::CMD_W-1:0]        cmd,
	input logic [bbst_pkg::POS_W-1:0]        position,
	input logic signed [bbst_pkg::LV_W-1:0]  leaf_value,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              balanced,
	input logic signed [bbst_pkg::OUT_W-1:0] total_sum,
	input logic signed [bbst_pkg::OUT_W-1:0] least_prefix
);

	import bbst_pkg::*;

	logic in_xfer;
	logic upd_xfer;
	logic qry_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign qry_xfer = in_xfer && (cmd == CMD_QUERY);
	assign upd_xfer = in_xfer && ((cmd == CMD_WRITE) || (cmd == CMD_FLIP)) &&
	                  (32'(position) < 32'(LEAVES));

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(balanced) &&
		$stable(total_sum) && $stable(least_prefix))
		else $error("stalled result changed");

	// A query transfer produces a result on the next cycle
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		qry_xfer |=> out_valid)
		else $error("query gave no result");

	// A taken result is not repeated without a new query
	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !qry_xfer |=> !out_valid)
		else $error("result repeated");

	// An update keeps the input busy while the tree is walked
	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		upd_xfer |=> in_stall)
		else $error("input taken during tree update");

	// Balanced implies zero total and zero least prefix
	a_balanced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && balanced |-> (total_sum == '0) && (least_prefix == '0))
		else $error("balanced flag disagrees with root values");

endmodule

bind bracket_balance_segment_tree bbst_check #(.LEAVES(LEAVES)) u_bbst_check (.*);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the bracket balance segment tree: random and directed commands.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bbst_pkg::*;

	localparam int NUM_LEAVES = LEAVES_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [LV_W-1:0] LV_OPEN      = 2'sb01;
	localparam logic signed [LV_W-1:0] LV_EMPTY     = 2'sb00;
	localparam logic signed [LV_W-1:0] LV_CLOSE     = 2'sb11;
	localparam logic signed [LV_W-1:0] LV_CLOSE_SAT = 2'sb10;
	localparam int TARGET_ITEMS   = 1250;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 32;

	typedef struct packed {
		logic [CMD_W-1:0]        op;
		logic [POS_W-1:0]        pos;
		logic signed [LV_W-1:0]  lv;
	} tree_cmd_t;

	typedef struct packed {
		logic                    bal;
		logic signed [OUT_W-1:0] total;
		logic signed [OUT_W-1:0] least;
	} balance_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CMD_W-1:0] cmd = CMD_QUERY;
	logic [POS_W-1:0] position = '0;
	logic signed [LV_W-1:0] leaf_value = LV_EMPTY;
	logic out_valid;
	logic out_stall = 1'b0;
	logic balanced;
	logic signed [OUT_W-1:0] total_sum;
	logic signed [OUT_W-1:0] least_prefix;

	tree_cmd_t pending_cmds[$];
	balance_t  expected_balance[$];
	int        dirty_pos[$];
	int        leaf_level[NUM_LEAVES];
	int        errors = 0;
	int        in_gap = 0;
	int        in_quiet = 0;
	int        stall_left = 0;
	int        out_quiet = 0;
	int        idle_cycles = 0;
	tree_cmd_t drive_cmd;
	balance_t  want;

	bracket_balance_segment_tree #(.LEAVES(NUM_LEAVES)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.position     (position),
		.leaf_value   (leaf_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.balanced     (balanced),
		.total_sum    (total_sum),
		.least_prefix (least_prefix)
	);

	always #4 clk = ~clk;

	// Update the leaf copy for a write or flip; for a query, queue the root summary
	function automatic void track_command(tree_cmd_t c);
		int run;
		int least;
		balance_t r;
		case (c.op)
			CMD_QUERY: begin
				run = 0;
				least = NUM_LEAVES + 1;
				for (int i = 0; i < NUM_LEAVES; i++) begin
					run += leaf_level[i];
					if (run < least)
						least = run;
				end
				r.bal   = (run == 0 && least == 0);
				r.total = run[OUT_W-1:0];
				r.least = least[OUT_W-1:0];
				expected_balance.push_back(r);
			end
			CMD_WRITE: begin
				if (c.pos < NUM_LEAVES) begin
					if (c.lv == LV_OPEN)
						leaf_level[c.pos] = 1;
					else if (c.lv == LV_EMPTY)
						leaf_level[c.pos] = 0;
					else
						leaf_level[c.pos] = -1;
				end
			end
			CMD_FLIP: begin
				if (c.pos < NUM_LEAVES)
					leaf_level[c.pos] = -leaf_level[c.pos];
			end
			default: ;
		endcase
	endfunction

	// Draw an idle length: mostly short, a few long, with quiet stretches of none
	function automatic int draw_gap(inout int quiet);
		int k;
		k = $urandom_range(0, 99);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if (k < 3) begin
			quiet = $urandom_range(20, 80);
			return 0;
		end
		if (k < 60)
			return 0;
		if (k < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic add_cmd(logic [CMD_W-1:0] op, int pos, logic signed [LV_W-1:0] lv);
		tree_cmd_t c;
		c.op  = op;
		c.pos = pos[POS_W-1:0];
		c.lv  = lv;
		pending_cmds.push_back(c);
	endtask

	function automatic logic signed [LV_W-1:0] any_close();
		return $urandom_range(0, 1) ? LV_CLOSE : LV_CLOSE_SAT;
	endfunction

	// Random command of any kind; remember touched leaves so they get cleared
	task automatic add_noise();
		int pos;
		logic [CMD_W-1:0] op;
		op = CMD_W'($urandom_range(0, 3));
		pos = $urandom_range(0, NUM_LEAVES - 1);
		add_cmd(op, pos, LV_W'($urandom_range(0, 3)));
		if (op == CMD_WRITE || op == CMD_FLIP)
			dirty_pos.push_back(pos);
	endtask

	// Write a random balanced bracket string into a region, query, maybe flip a leaf and back, clear it
	task automatic add_episode();
		int len;
		int base;
		int depth;
		int k;
		int j;
		int tmp;
		int word[$];
		int order[$];
		k = $urandom_range(0, 99);
		if (k < 2)
			len = 128;
		else if (k < 12)
			len = 2 * $urandom_range(9, 32);
		else
			len = 2 * $urandom_range(1, 8);
		base = $urandom_range(0, NUM_LEAVES - len);
		depth = 0;
		for (int i = 0; i < len; i++) begin
			if (depth == len - i || (depth > 0 && $urandom_range(0, 1))) begin
				word.push_back(-1);
				depth--;
			end else begin
				word.push_back(1);
				depth++;
			end
			order.push_back(i);
		end
		// shuffle the write order
		for (int i = len - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			if ($urandom_range(0, 99) < 8)
				add_noise();
			add_cmd(CMD_WRITE, base + order[i], word[order[i]] == 1 ? LV_OPEN : any_close());
			dirty_pos.push_back(base + order[i]);
			if ($urandom_range(0, 99) < 5)
				add_cmd(CMD_QUERY, $urandom_range(0, NUM_LEAVES - 1),
					LV_W'($urandom_range(0, 3)));
		end
		add_cmd(CMD_QUERY, $urandom_range(0, NUM_LEAVES - 1), LV_W'($urandom_range(0, 3)));
		if ($urandom_range(0, 1)) begin
			j = base + $urandom_range(0, len - 1);
			add_cmd(CMD_FLIP, j, LV_W'($urandom_range(0, 3)));
			add_cmd(CMD_QUERY, $urandom_range(0, NUM_LEAVES - 1), LV_W'($urandom_range(0, 3)));
			add_cmd(CMD_FLIP, j, LV_W'($urandom_range(0, 3)));
			add_cmd(CMD_QUERY, $urandom_range(0, NUM_LEAVES - 1), LV_W'($urandom_range(0, 3)));
		end
		// return every touched leaf to empty
		while (dirty_pos.size() > 0) begin
			add_cmd(CMD_WRITE, dirty_pos.pop_front(), LV_EMPTY);
			if ($urandom_range(0, 99) < 3)
				add_cmd(CMD_QUERY, $urandom_range(0, NUM_LEAVES - 1),
					LV_W'($urandom_range(0, 3)));
		end
		if ($urandom_range(0, 1))
			add_cmd(CMD_QUERY, $urandom_range(0, NUM_LEAVES - 1), LV_W'($urandom_range(0, 3)));
	endtask

	task automatic tmp_stall();
		int len;
		len = draw_gap(out_quiet);
		out_stall <= (len > 0);
		stall_left <= (len > 0) ? len - 1 : 0;
	endtask

	// Driver: record each transfer, then present the next command after its gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				track_command(tree_cmd_t'{cmd, position, leaf_value});
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_cmds.size() > 0) begin
				drive_cmd = pending_cmds.pop_front();
				cmd <= drive_cmd.op;
				position <= drive_cmd.pos;
				leaf_value <= drive_cmd.lv;
				in_valid <= 1'b1;
				in_gap <= draw_gap(in_quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expected summary
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_balance.size() == 0) begin
					$display("%0t: result with none expected: balanced %0b total %0d least %0d",
						$time, balanced, total_sum, least_prefix);
					errors++;
				end else begin
					want = expected_balance.pop_front();
					if (balanced !== want.bal) begin
						$display("%0t: balanced expected %0b got %0b", $time, want.bal, balanced);
						errors++;
					end
					if (total_sum !== want.total) begin
						$display("%0t: total_sum expected %0d got %0d", $time, want.total,
							total_sum);
						errors++;
					end
					if (least_prefix !== want.least) begin
						$display("%0t: least_prefix expected %0d got %0d", $time, want.least,
							least_prefix);
						errors++;
					end
				end
			end
			// hold the stall for its drawn length, then draw again
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else begin
				tmp_stall();
			end
		end
	end

	// Watchdog: end the run if nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// directed: empty tree, end leaves, saturated close, empty flip, unused command
		add_cmd(CMD_QUERY, 0, LV_EMPTY);
		add_cmd(CMD_WRITE, 0, LV_OPEN);
		add_cmd(CMD_QUERY, NUM_LEAVES - 1, LV_CLOSE);
		add_cmd(CMD_WRITE, NUM_LEAVES - 1, LV_CLOSE);
		add_cmd(CMD_QUERY, 0, LV_OPEN);
		add_cmd(CMD_WRITE, NUM_LEAVES - 1, LV_CLOSE_SAT);
		add_cmd(CMD_QUERY, 0, LV_CLOSE_SAT);
		add_cmd(CMD_FLIP, 0, LV_OPEN);
		add_cmd(CMD_QUERY, 0, LV_EMPTY);
		add_cmd(CMD_FLIP, NUM_LEAVES / 2, LV_CLOSE);
		add_cmd(CMD_QUERY, 0, LV_EMPTY);
		add_cmd(CMD_UNUSED, 0, LV_OPEN);
		add_cmd(CMD_UNUSED, NUM_LEAVES - 1, LV_CLOSE);
		add_cmd(CMD_QUERY, 0, LV_EMPTY);
		add_cmd(CMD_FLIP, 0, LV_CLOSE);
		add_cmd(CMD_QUERY, 0, LV_EMPTY);
		add_cmd(CMD_FLIP, NUM_LEAVES - 1, LV_EMPTY);
		add_cmd(CMD_QUERY, NUM_LEAVES - 1, LV_OPEN);
		add_cmd(CMD_WRITE, 0, LV_EMPTY);
		add_cmd(CMD_WRITE, NUM_LEAVES - 1, LV_EMPTY);
		add_cmd(CMD_QUERY, 0, LV_EMPTY);
		while (pending_cmds.size() < TARGET_ITEMS)
			add_episode();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain: every command taken and every result checked
		do
			@(negedge clk);
		while (pending_cmds.size() > 0 || in_valid || expected_balance.size() > 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> files.f
src/bbst_pkg.sv
src/bbst_ram.sv
src/bracket_balance_segment_tree.sv
src/bbst_check.sv
tb/sv/tb_top.sv
